// ===== design/tcw_pkg.sv =====
// Package with the geometry, codes, types and state encoding of the text console writer.
`default_nettype none
package tcw_pkg;

	// Screen geometry.
	localparam int COLUMNS = 80;
	localparam int ROWS = 25;
	localparam int CELLS = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W = 7;
	localparam int ROW_W = 5;

	// Attribute register value after reset.
	localparam logic [7:0] ATTR_RESET = 8'h07;

	// Character codes with special meaning.
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_DEL = 8'h7f;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Request opcodes.
	localparam logic OP_PUT = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct packed {
		logic opcode;
		logic [7:0] char_code;
		logic [ROW_W-1:0] read_row;
		logic [COL_W-1:0] read_col;
	} tcw_req_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic [COL_W-1:0] cursor_col;
		logic [ROW_W-1:0] cursor_row;
		logic did_scroll;
	} tcw_rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COPY,
		ST_ZERO,
		ST_WRITE,
		ST_DONE
	} tcw_state_t;

endpackage
`default_nettype wire

// ===== design/text_console_writer_top.sv =====
// Text console writer: cell store, cursor logic, scroll walk and result register.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_req  (tcw_req_t)
// out      output     out_valid / out_ready  out_rsp (tcw_rsp_t)
// cfg      input      cfg_we                 cfg_wdata (attribute byte)
//
// A read or a put without scroll uses the store when taken, then loads the result register
// in the finish step. A put that scrolls walks the store through its single write port: it
// copies (ROWS-1)*COLUMNS cells a row up, drains the last copy write, zeroes the COLUMNS
// bottom cells. After reset a clearing pass writes zero to all CELLS (2000) entries,
// one per cycle, and no request is taken until it ends. A result waiting in the output
// register does not hold off a new request; only the finish step stalls until it is free.
`default_nettype none
module text_console_writer_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire tcw_pkg::tcw_req_t in_req,
	output logic out_valid,
	input wire logic out_ready,
	output tcw_pkg::tcw_rsp_t out_rsp,
	input wire logic cfg_we,
	input wire logic [7:0] cfg_wdata
);
	import tcw_pkg::*;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'((ROWS - 1) * COLUMNS - 1);
	localparam logic [ADDR_W-1:0] BOTTOM_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
	localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);

	tcw_state_t state_q, state_d;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [7:0] attr_q;
	logic [7:0] ch_q;
	logic prn_q;
	logic scroll_q;
	logic is_read_q;
	logic rd_ok_q;
	logic [ADDR_W-1:0] cnt_q;
	logic wr_pend_q;
	logic [ADDR_W-1:0] wr_addr_q;
	logic out_valid_q;
	tcw_rsp_t out_q;

	// Memory port signals.
	logic mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [15:0] mem_wdata;
	logic mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [15:0] mem_rdata;
	logic [15:0] mem [CELLS];

	logic accept;
	logic out_load;
	logic [COL_W-1:0] col_n;
	logic [ROW_W-1:0] row_n;
	logic put_prn;
	logic put_scroll;
	logic rd_in_range;
	logic [ADDR_W-1:0] put_addr;
	logic [ADDR_W-1:0] rd_addr;

	assign accept = in_valid && in_ready;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// Cursor update for a put request, from the current cursor.
	always_comb begin
		col_n = col_q;
		row_n = row_q;
		put_prn = 1'b0;
		if (in_req.char_code == CH_CR) begin
			col_n = '0;
		end else if (in_req.char_code == CH_BS || in_req.char_code == CH_DEL) begin
			if (col_q != '0) begin
				col_n = col_q - COL_W'(1);
			end
		end else if (in_req.char_code == CH_LF) begin
			row_n = row_q + ROW_W'(1);
			col_n = '0;
		end else if (in_req.char_code >= CH_SPACE) begin
			put_prn = 1'b1;
			if (col_q >= COL_W'(COLUMNS)) begin
				col_n = '0;
				row_n = row_q + ROW_W'(1);
			end
		end
		put_scroll = (in_req.char_code == CH_LF || put_prn) && (row_n >= ROW_W'(ROWS));
	end

	// Store addresses for the incoming request.
	assign put_addr = ADDR_W'(row_n) * ROW_STRIDE + ADDR_W'(col_n);
	assign rd_addr = ADDR_W'(in_req.read_row) * ROW_STRIDE + ADDR_W'(in_req.read_col);
	assign rd_in_range = (in_req.read_row < ROW_W'(ROWS)) && (in_req.read_col < COL_W'(COLUMNS));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (cnt_q == LAST_ADDR) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (in_req.opcode == OP_PUT && put_scroll) state_d = ST_COPY;
					else state_d = ST_DONE;
				end
			end
			ST_COPY: begin
				if (cnt_q == COPY_LAST) state_d = ST_ZERO;
			end
			ST_ZERO: begin
				if (!wr_pend_q && cnt_q == LAST_ADDR) state_d = prn_q ? ST_WRITE : ST_DONE;
			end
			ST_WRITE: state_d = ST_DONE;
			ST_DONE: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// Memory port control and handshake outputs.
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		mem_we = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = '0;
		mem_re = 1'b0;
		mem_raddr = rd_addr;
		unique case (state_q)
			ST_CLEAR: mem_we = 1'b1;
			ST_IDLE: begin
				if (accept && in_req.opcode == OP_READ) begin
					mem_re = rd_in_range;
				end else if (accept && put_prn && !put_scroll) begin
					mem_we = 1'b1;
					mem_waddr = put_addr;
					mem_wdata = {attr_q, in_req.char_code};
				end
			end
			ST_COPY: begin
				mem_re = 1'b1;
				mem_raddr = cnt_q + ROW_STRIDE;
				if (wr_pend_q) begin
					mem_we = 1'b1;
					mem_waddr = wr_addr_q;
					mem_wdata = mem_rdata;
				end
			end
			ST_ZERO: begin
				mem_we = 1'b1;
				if (wr_pend_q) begin
					mem_waddr = wr_addr_q;
					mem_wdata = mem_rdata;
				end
			end
			ST_WRITE: begin
				mem_we = 1'b1;
				mem_waddr = BOTTOM_BASE;
				mem_wdata = {attr_q, ch_q};
			end
			ST_DONE: ;
			default: ;
		endcase
	end

	// Cell store with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) mem_rdata <= mem[mem_raddr];
	end

	// Control state, cursor and walk counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			col_q <= '0;
			row_q <= '0;
			attr_q <= ATTR_RESET;
			cnt_q <= '0;
			wr_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
			prn_q <= 1'b0;
			scroll_q <= 1'b0;
			is_read_q <= 1'b0;
			rd_ok_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) attr_q <= cfg_wdata;
			unique case (state_q)
				ST_CLEAR: cnt_q <= cnt_q + ADDR_W'(1);
				ST_IDLE: begin
					if (accept) begin
						is_read_q <= (in_req.opcode == OP_READ);
						rd_ok_q <= rd_in_range;
						scroll_q <= 1'b0;
						prn_q <= put_prn;
						cnt_q <= '0;
						if (in_req.opcode == OP_PUT) begin
							if (put_scroll) begin
								col_q <= '0;
								row_q <= ROW_W'(ROWS - 1);
								scroll_q <= 1'b1;
							end else begin
								col_q <= put_prn ? col_n + COL_W'(1) : col_n;
								row_q <= row_n;
							end
						end
					end
				end
				ST_COPY: begin
					wr_pend_q <= 1'b1;
					cnt_q <= cnt_q + ADDR_W'(1);
				end
				ST_ZERO: begin
					if (wr_pend_q) wr_pend_q <= 1'b0;
					else if (cnt_q != LAST_ADDR) cnt_q <= cnt_q + ADDR_W'(1);
				end
				ST_WRITE: col_q <= COL_W'(1);
				ST_DONE: ;
				default: ;
			endcase
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Copy write address trails the read address by one row.
	always_ff @(posedge clk) begin
		if (state_q == ST_COPY) wr_addr_q <= cnt_q;
		if (accept) ch_q <= in_req.char_code;
		if (out_load) begin
			out_q.read_data <= (is_read_q && rd_ok_q) ? mem_rdata : 16'h0000;
			out_q.cursor_col <= col_q;
			out_q.cursor_row <= row_q;
			out_q.did_scroll <= scroll_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rsp = out_q;

`ifndef ASSERT_OFF
	// No copy write may still be pending when a new request can enter.
	a_no_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !wr_pend_q)
		else $error("copy write pending in idle");

	// Every copy read is followed by its write in the next cycle.
	a_copy_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COPY) |=> mem_we)
		else $error("copy read without write");

	// The cursor stays on the screen, with a pending wrap at most.
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(row_q < ROW_W'(ROWS)) && (col_q <= COL_W'(COLUMNS)))
		else $error("cursor out of range");

	// A result register that is taken during the finish step is refilled.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q)
		else $error("result lost");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_text_console_writer_top.sv =====
// Self-checking testbench for the text console writer, with its own screen and cursor tracker.
module tb_text_console_writer_top;
	import tcw_pkg::*;

	localparam int CYCLE_LIMIT = 15_000_000;
	localparam int LONG_HOLD = 600;
	localparam int TAIL_CYCLES = 2100;
	localparam int PHASE_REQS = 330;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	tcw_req_t in_req = '0;
	logic out_valid;
	logic out_ready = 1'b1;
	tcw_rsp_t out_rsp;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_wdata = '0;

	// Screen tracker: cell contents, cursor and attribute as the block should hold them.
	logic [15:0] screen [CELLS];
	int cur_col = 0;
	int cur_row = 0;
	logic [7:0] text_attr = ATTR_RESET;

	tcw_req_t pending_req [$];
	tcw_rsp_t awaited_rsp [$];
	int req_taken = 0;
	int rsp_taken = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	// Sender and receiver bookkeeping.
	int req_offered = 0;
	int tx_gap = 0;
	int tx_calm = 0;
	int rx_seen = 0;
	int rx_left = 0;
	int rx_calm = 0;
	int rx_wait;

	text_console_writer_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_req(in_req),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_rsp(out_rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	// Applies one request to the tracked screen and returns the response it should produce.
	function automatic tcw_rsp_t console_apply(input tcw_req_t rq);
		tcw_rsp_t rsp;
		logic [7:0] ch;
		rsp = '0;
		ch = rq.char_code;
		if (rq.opcode == OP_READ) begin
			if (rq.read_row < ROWS && rq.read_col < COLUMNS)
				rsp.read_data = screen[rq.read_row * COLUMNS + rq.read_col];
		end else if (ch == CH_CR) begin
			cur_col = 0;
		end else if (ch == CH_BS || ch == CH_DEL) begin
			if (cur_col > 0)
				cur_col = cur_col - 1;
		end else if (ch == CH_LF || ch >= CH_SPACE) begin
			if (ch == CH_LF) begin
				cur_row = cur_row + 1;
				cur_col = 0;
			end else if (cur_col >= COLUMNS) begin
				cur_col = 0;
				cur_row = cur_row + 1;
			end
			// Leaving the last row shifts every row up and blanks the bottom one.
			if (cur_row >= ROWS) begin
				for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
					screen[i] = screen[i + COLUMNS];
				for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
					screen[i] = '0;
				cur_col = 0;
				cur_row = ROWS - 1;
				rsp.did_scroll = 1'b1;
			end
			if (ch != CH_LF) begin
				screen[cur_row * COLUMNS + cur_col] = {text_attr, ch};
				cur_col = cur_col + 1;
			end
		end
		rsp.cursor_col = COL_W'(cur_col);
		rsp.cursor_row = ROW_W'(cur_row);
		return rsp;
	endfunction

	function automatic int field_differs(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
			return 1;
		end
		return 0;
	endfunction

	function automatic tcw_req_t make_req(input logic op, input logic [7:0] ch,
			input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
		tcw_req_t rq;
		rq.opcode = op;
		rq.char_code = ch;
		rq.read_row = r;
		rq.read_col = c;
		return rq;
	endfunction

	// A put request; the unused read fields carry random bits.
	function automatic tcw_req_t put_req(input logic [7:0] ch);
		return make_req(OP_PUT, ch, ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
	endfunction

	// A read request; the unused character field carries random bits.
	function automatic tcw_req_t read_req(input int r, input int c);
		return make_req(OP_READ, 8'($urandom_range(0, 255)), ROW_W'(r), COL_W'(c));
	endfunction

	// A random printable byte, DEL excluded.
	function automatic logic [7:0] random_glyph();
		int b;
		b = $urandom_range(32, 254);
		if (b >= 127)
			b = b + 1;
		return 8'(b);
	endfunction

	// Clock cycle counter with the run timeout.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** text_console_writer_top: FAILED **");
			$finish;
		end
	end

	// Monitor: checks each response against the oldest expectation, then predicts new requests.
	always @(posedge clk) begin
		tcw_rsp_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (awaited_rsp.size() == 0) begin
					$error("response with none expected: read_data 0x%0h col %0d row %0d scroll %0b",
						out_rsp.read_data, out_rsp.cursor_col, out_rsp.cursor_row,
						out_rsp.did_scroll);
					mismatch_count = mismatch_count + 1;
				end else begin
					want = awaited_rsp.pop_front();
					mismatch_count = mismatch_count
						+ field_differs("read_data", want.read_data, out_rsp.read_data)
						+ field_differs("cursor_col", 16'(want.cursor_col), 16'(out_rsp.cursor_col))
						+ field_differs("cursor_row", 16'(want.cursor_row), 16'(out_rsp.cursor_row))
						+ field_differs("did_scroll", 16'(want.did_scroll), 16'(out_rsp.did_scroll));
				end
				rsp_taken <= rsp_taken + 1;
			end
			if (in_valid && in_ready) begin
				awaited_rsp.push_back(console_apply(in_req));
				req_taken <= req_taken + 1;
			end
		end
	end

	// Driver: presents queued requests, with a random gap after each accepted request.
	always @(negedge clk) begin
		if (!in_valid || req_taken == req_offered) begin
			if (tx_gap != 0) begin
				in_valid <= 1'b0;
				tx_gap <= tx_gap - 1;
			end else if (pending_req.size() != 0) begin
				in_req <= pending_req.pop_front();
				in_valid <= 1'b1;
				req_offered <= req_offered + 1;
				tx_gap <= (tx_calm != 0) ? 0 : $urandom_range(0, 19);
				tx_calm <= (tx_calm != 0) ? tx_calm - 1
					: (($urandom_range(0, 39) == 0) ? $urandom_range(10, 40) : 0);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: stalls a random number of cycles after each response, and twice for a long time.
	always @(negedge clk) begin
		if (rx_seen != rsp_taken) begin
			rx_seen <= rsp_taken;
			if (rsp_taken == 400 || rsp_taken == 1200)
				rx_wait = LONG_HOLD;
			else
				rx_wait = (rx_calm != 0) ? 0 : $urandom_range(0, 19);
			rx_calm <= (rx_calm != 0) ? rx_calm - 1
				: (($urandom_range(0, 39) == 0) ? $urandom_range(10, 40) : 0);
			rx_left <= rx_wait;
			out_ready <= (rx_wait == 0);
		end else if (rx_left != 0) begin
			rx_left <= rx_left - 1;
			out_ready <= (rx_left == 1);
		end
	end

	// Waits until every queued request went in and every response came back.
	task automatic wait_until_drained();
		do
			@(negedge clk);
		while (pending_req.size() != 0 || in_valid || awaited_rsp.size() != 0);
	endtask

	// Stimulus: directed requests, then random phases under different attribute settings.
	initial begin : stimulus
		logic [7:0] attr_plan [5];
		int kind;
		int n;
		int useful;
		bit first_seq;
		tcw_req_t rq;

		foreach (screen[i])
			screen[i] = '0;
		attr_plan[0] = 8'h00;
		attr_plan[1] = 8'hff;
		attr_plan[2] = 8'($urandom_range(1, 254));
		attr_plan[3] = 8'h80;
		attr_plan[4] = 8'($urandom_range(1, 254));

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed requests starting from the blank screen at the home position.
		pending_req.push_back(read_req(0, 0));
		pending_req.push_back(put_req(8'h41));
		pending_req.push_back(put_req(8'hff));
		pending_req.push_back(put_req(8'h80));
		pending_req.push_back(put_req(CH_SPACE));
		pending_req.push_back(put_req(CH_BS));
		pending_req.push_back(put_req(CH_DEL));
		pending_req.push_back(put_req(8'h00));
		pending_req.push_back(put_req(8'h1f));
		pending_req.push_back(put_req(CH_CR));
		pending_req.push_back(put_req(CH_BS));
		pending_req.push_back(put_req(CH_LF));
		pending_req.push_back(put_req(8'h7e));
		pending_req.push_back(read_req(0, 0));
		pending_req.push_back(read_req(0, 1));
		pending_req.push_back(read_req(0, 2));
		pending_req.push_back(read_req(1, 0));
		pending_req.push_back(read_req(ROWS - 1, COLUMNS - 1));
		pending_req.push_back(read_req(ROWS, 0));
		pending_req.push_back(read_req(0, COLUMNS));
		pending_req.push_back(make_req(OP_READ, 8'hff, 5'h1f, 7'h7f));
		pending_req.push_back(make_req(OP_PUT, 8'h5a, 5'h1f, 7'h7f));
		pending_req.push_back(put_req(CH_LF));
		pending_req.push_back(read_req(1, 1));
		wait_until_drained();

		for (int phase = 0; phase < 5; phase++) begin
			// The block is idle here, so the attribute can change.
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_wdata <= attr_plan[phase];
			@(negedge clk);
			cfg_we <= 1'b0;
			text_attr = attr_plan[phase];

			useful = 0;
			first_seq = 1'b1;
			while (useful < PHASE_REQS) begin
				kind = first_seq ? 62 : $urandom_range(0, 99);
				first_seq = 1'b0;
				if (kind < 45) begin
					// A run of text with the odd backspace or delete.
					n = $urandom_range(1, 30);
					for (int j = 0; j < n; j++) begin
						if ($urandom_range(0, 19) == 0)
							rq = put_req($urandom_range(0, 1) ? CH_BS : CH_DEL);
						else
							rq = put_req(random_glyph());
						pending_req.push_back(rq);
					end
					useful = useful + n;
				end else if (kind < 58) begin
					// Reads, mostly inside the screen.
					n = $urandom_range(1, 6);
					for (int j = 0; j < n; j++) begin
						if ($urandom_range(0, 99) < 85)
							rq = read_req($urandom_range(0, ROWS - 1), $urandom_range(0, COLUMNS - 1));
						else
							rq = read_req($urandom_range(0, 31), $urandom_range(0, 127));
						pending_req.push_back(rq);
					end
					useful = useful + n;
				end else if (kind < 60) begin
					// Line ends: a few line feeds, sometimes after a carriage return.
					if ($urandom_range(0, 1)) begin
						pending_req.push_back(put_req(CH_CR));
						useful = useful + 1;
					end
					n = $urandom_range(1, 3);
					for (int j = 0; j < n; j++)
						pending_req.push_back(put_req(CH_LF));
					useful = useful + n;
				end else if (kind < 65) begin
					// A full line that leaves a wrap pending, then an edit, more text or a line feed.
					pending_req.push_back(put_req(CH_CR));
					for (int j = 0; j < COLUMNS; j++)
						pending_req.push_back(put_req(random_glyph()));
					case ($urandom_range(0, 3))
						0: pending_req.push_back(put_req(CH_BS));
						1: pending_req.push_back(put_req(CH_DEL));
						2: pending_req.push_back(put_req(random_glyph()));
						default: pending_req.push_back(put_req(CH_LF));
					endcase
					useful = useful + COLUMNS + 2;
				end else if (kind < 72) begin
					// More line feeds so the screen scrolls often.
					n = $urandom_range(1, 4);
					for (int j = 0; j < n; j++)
						pending_req.push_back(put_req(CH_LF));
					useful = useful + n;
				end else if (kind < 88) begin
					// Noise: fully random requests.
					n = $urandom_range(1, 4);
					for (int j = 0; j < n; j++) begin
						rq = make_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
							ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
						pending_req.push_back(rq);
						if (rq.opcode == OP_READ || rq.char_code >= CH_SPACE
								|| rq.char_code == CH_CR || rq.char_code == CH_LF
								|| rq.char_code == CH_BS)
							useful = useful + 1;
					end
				end else begin
					// Cursor edits and random control bytes, most of which the block ignores.
					case ($urandom_range(0, 3))
						0: begin
							pending_req.push_back(put_req(CH_CR));
							useful = useful + 1;
						end
						1: begin
							pending_req.push_back(put_req(CH_BS));
							useful = useful + 1;
						end
						2: begin
							pending_req.push_back(put_req(CH_DEL));
							useful = useful + 1;
						end
						default: pending_req.push_back(put_req(8'($urandom_range(0, 31))));
					endcase
				end
			end
			wait_until_drained();
		end

		// Quiet tail long enough for a scroll walk, to catch stray responses.
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("** text_console_writer_top: PASSED **");
		else
			$display("** text_console_writer_top: FAILED **");
		$finish;
	end

endmodule
